// ===== rtl/core/tsce_pkg.sv =====
// ----------------------------------------------------------------------------
// Taylor series evaluator package
// Shared widths, constants and the per-cell data record.
// ----------------------------------------------------------------------------
package tsce_pkg;

  localparam int unsigned AW = 64;

  // Table geometry, fixed by the 4-bit channel and term fields.
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned MAX_TERMS    = 16;

  localparam logic [1:0] REG_CH_FIRST = 2'd0;
  localparam logic [1:0] REG_NUM_CH   = 2'd1;
  localparam logic [1:0] REG_SPATIAL  = 2'd2;
  localparam logic [1:0] REG_TERMS    = 2'd3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Record handed from one cell to the next.
  typedef struct packed {
    logic                 vld;
    logic signed [31:0]   x;
    logic signed [31:0]   t;
    logic signed [AW-1:0] acc;
    logic [3:0]           ch;
    logic                 sat;
    logic [5:0]           nt;
    logic                 zero;
  } cell_data_t;

endpackage

// ===== rtl/core/taylor_series_channel_eval_top.sv =====
// ----------------------------------------------------------------------------
// Taylor series channel evaluator, top level
// Streams Q16.16 samples and returns per-channel Taylor series values.
// ----------------------------------------------------------------------------
// Usage: in_tdata carries value and the coefficient address, in_tuser marks a
// coefficient load (1) or a data sample (0). Loads write the coefficient
// table and give no output transaction. Each sample gives one output
// transaction with the series value, the applied channel and a clip flag.
// The datapath is a row of MAX_TERMS-1 term cells, three stages each, fed
// from a first stage that reads the coefficient table; a sample passes the
// head stage, the cells and then the output register, and one sample enters
// per cycle while the receiver does not stall. The coefficient for each cell
// is read as the sample enters and travels with it in a per-cell delay line.
// Reset clears the counters, the configuration and all valid bits; the table
// holds garbage until written. When the receiver stalls the whole row
// holds, and the input is stalled with it.
// ----------------------------------------------------------------------------
module taylor_series_channel_eval_top #(
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], coeff_channel[35:32], coeff_term[39:36]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value[31:0], result_channel[35:32], zeros
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  import tsce_pkg::*;

  localparam int unsigned NC = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;

  logic        ch_first_r;
  logic [4:0]  num_ch_r, terms_r;
  logic [24:0] spatial_r;
  logic [3:0]  chan_r, chan_nxt;
  logic [23:0] spat_r, spat_nxt;

  // Coefficient table read ports, one bank per term.
  logic signed [31:0] bank_rd [MAX_TERMS];
  logic signed [31:0] coef_r [NC];
  logic signed [31:0] coef_d [NC];

  cell_data_t head_r;
  cell_data_t link [NC+1];
  logic en;
  logic acc_in, is_data;
  logic [8:0]  nch;
  logic [5:0]  nt;
  logic [24:0] ns;
  logic signed [63:0] fin;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc_in    = in_tvalid && in_tready;
  assign is_data   = (in_tuser == KIND_DATA);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_first_r <= 1'b0;
      num_ch_r   <= 5'd1;
      spatial_r  <= 25'd1;
      terms_r    <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CH_FIRST: ch_first_r <= cfg_data[0];
        REG_NUM_CH:   num_ch_r   <= cfg_data[4:0];
        REG_SPATIAL:  spatial_r  <= cfg_data;
        REG_TERMS:    terms_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clamped limits.
  always_comb begin
    nch = (num_ch_r == 5'd0) ? 9'd1 : 9'(num_ch_r);
    if (nch > 9'(MAX_CHANNELS)) nch = 9'(MAX_CHANNELS);
    nt = (terms_r == 5'd0) ? 6'd1 : 6'(terms_r);
    if (nt > 6'(MAX_TERMS)) nt = 6'(MAX_TERMS);
    ns = (spatial_r == 25'd0) ? 25'd1 : spatial_r;
    if (ns > 25'h1000000) ns = 25'h1000000;
  end

  // Position counters.
  always_comb begin
    chan_nxt = chan_r;
    spat_nxt = spat_r;
    if (ch_first_r) begin
      if (25'(spat_r) + 25'd1 >= ns) begin
        spat_nxt = '0;
        chan_nxt = (9'(chan_r) + 9'd1 >= nch) ? 4'd0 : chan_r + 4'd1;
      end else begin
        spat_nxt = spat_r + 24'd1;
      end
    end else begin
      if (9'(chan_r) + 9'd1 >= nch) begin
        chan_nxt = '0;
        spat_nxt = (25'(spat_r) + 25'd1 >= ns) ? 24'd0 : spat_r + 24'd1;
      end else begin
        chan_nxt = chan_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      spat_r <= '0;
    end else if (acc_in && is_data) begin
      chan_r <= chan_nxt;
      spat_r <= spat_nxt;
    end
  end

  // Coefficient table: one bank per term, indexed by channel.
  for (genvar b = 0; b < MAX_TERMS; b++) begin : g_bank
    logic signed [31:0] bank_r [MAX_CHANNELS];
    always_ff @(posedge clk) begin
      if (acc_in && !is_data && (in_tdata[39:36] == 4'(b)))
        bank_r[in_tdata[35:32]] <= in_tdata[31:0];
    end
    assign bank_rd[b] = bank_r[chan_r];
  end

  // Head stage: reads the row, starts t at one and acc at coef[0].
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (en) begin
      head_r.vld  <= acc_in && is_data;
      head_r.x    <= in_tdata[31:0];
      head_r.t    <= 32'sd1 <<< FRAC_BITS;
      head_r.ch   <= chan_r;
      head_r.sat  <= 1'b0;
      head_r.nt   <= nt;
      head_r.zero <= 32'(chan_r) >= MAX_CHANNELS;
      head_r.acc  <= (32'(chan_r) >= MAX_CHANNELS) ? 64'sd0 : 64'(bank_rd[0]);
      for (int k = 0; k < NC; k++)
        coef_r[k] <= bank_rd[4'(k + 1)];
    end
  end

  assign link[0] = head_r;

  // Row of term cells; each cell's coefficient follows its sample to stage 3.
  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic signed [31:0] dly_r [3*g+2];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= coef_r[g];
        for (int k = 1; k < 3 * g + 2; k++) dly_r[k] <= dly_r[k-1];
      end
    end
    assign coef_d[g] = dly_r[3*g+1];
    tsce_cell #(.FRAC_BITS(FRAC_BITS), .TERM(g + 1)) u_cell (
      .clk, .rst_n, .en,
      .d_in (link[g]),
      .coef (coef_d[g]),
      .d_out(link[g+1])
    );
  end

  // Output register with final saturation.
  assign fin = link[NC].acc;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= link[NC].vld && (MAX_TERMS > 1);
      out_tdata[39:36] <= 4'd0;
      out_tdata[35:32] <= link[NC].ch;
      if (fin > 64'sd2147483647) begin
        out_tdata[31:0] <= 32'h7fffffff; out_tuser <= 1'b1;
      end else if (fin < -64'sd2147483648) begin
        out_tdata[31:0] <= 32'h80000000; out_tuser <= 1'b1;
      end else begin
        out_tdata[31:0] <= fin[31:0];    out_tuser <= link[NC].sat;
      end
    end
  end

endmodule

// ===== rtl/core/tsce_cell.sv =====
// ----------------------------------------------------------------------------
// Taylor series term cell
// Evaluates one series term: scales x by 1/i, updates the power term and
// adds coef*t into the accumulator. Three register stages.
// ----------------------------------------------------------------------------
module tsce_cell #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TERM      = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tsce_pkg::cell_data_t  d_in,
  input  logic signed [31:0]    coef,
  output tsce_pkg::cell_data_t  d_out
);
  import tsce_pkg::*;

  localparam longint RECIP = ((64'sd1 <<< FRAC_BITS) + TERM / 2) / TERM;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  cell_data_t s1_r, s2_r, s3_r;
  cell_data_t s1_nxt, s2_nxt, s3_nxt;
  logic signed [31:0] q_r;
  logic signed [63:0] p1, p2, p3, r1, r2, r3;
  logic active;
  logic sat1, sat2;
  logic signed [31:0] q_nxt, t_nxt;

  assign active = (d_in.nt > 6'(TERM)) && !d_in.zero;

  // Stage 1: q = rnd(x * r_i).
  assign p1 = 64'(d_in.x) * RECIP;
  assign r1 = (p1 + HALF) >>> FRAC_BITS;
  always_comb begin
    sat1 = 1'b0;
    q_nxt = r1[31:0];
    if (r1 > MAXV) begin
      sat1 = 1'b1; q_nxt = 32'sh7fffffff;
    end else if (r1 < MINV) begin
      sat1 = 1'b1; q_nxt = 32'sh80000000;
    end
  end

  always_comb begin
    s1_nxt = d_in;
    if (active) s1_nxt.sat = d_in.sat | sat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      q_r  <= q_nxt;
    end
  end

  // Stage 2: t = rnd(t * q).
  assign p2 = 64'(s1_r.t) * 64'(q_r);
  assign r2 = (p2 + HALF) >>> FRAC_BITS;
  always_comb begin
    sat2 = 1'b0;
    t_nxt = r2[31:0];
    if (r2 > MAXV) begin
      sat2 = 1'b1; t_nxt = 32'sh7fffffff;
    end else if (r2 < MINV) begin
      sat2 = 1'b1; t_nxt = 32'sh80000000;
    end
  end

  always_comb begin
    s2_nxt = s1_r;
    if ((s1_r.nt > 6'(TERM)) && !s1_r.zero) begin
      s2_nxt.t   = t_nxt;
      s2_nxt.sat = s1_r.sat | sat2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: acc += rnd(coef * t).
  assign p3 = 64'(coef) * 64'(s2_r.t);
  assign r3 = (p3 + HALF) >>> FRAC_BITS;

  always_comb begin
    s3_nxt = s2_r;
    if ((s2_r.nt > 6'(TERM)) && !s2_r.zero) s3_nxt.acc = s2_r.acc + r3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  assign d_out = s3_r;

endmodule
